@@ src/tdse_pkg.sv @@
// Shared constants, codes and control/status types of the typed data stack engine.
package tdse_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned VALUE_WIDTH = 64;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned TAG_W      = 2;
  localparam int unsigned PORT_VAL_W = 64;
  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned SP_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(STACK_DEPTH);
  localparam int unsigned IDX_W      = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 3'd0,
    OP_DUP  = 3'd1,
    OP_DROP = 3'd2,
    OP_SWAP = 3'd3,
    OP_ROT  = 3'd4,
    OP_PICK = 3'd5
  } op_e;

  typedef enum logic [TAG_W-1:0] {
    TAG_LONG   = 2'd0,
    TAG_DOUBLE = 2'd1,
    TAG_CHAR   = 2'd2,
    TAG_STR    = 2'd3
  } tag_e;

  typedef enum logic [2:0] {
    ADDR_SP,
    ADDR_SP_M1,
    ADDR_SP_M2,
    ADDR_SP_M3,
    ADDR_PICK
  } addr_sel_e;

  typedef enum logic [2:0] {
    WD_IN,
    WD_A,
    WD_B,
    WD_C,
    WD_RD
  } wdata_sel_e;

  typedef enum logic [1:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC
  } sp_op_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_A,
    CAP_B,
    CAP_C
  } cap_sel_e;

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  typedef struct packed {
    logic       in_ready;
    logic       rd_en;
    addr_sel_e  rd_addr;
    logic       wr_en;
    addr_sel_e  wr_addr;
    wdata_sel_e wr_data;
    sp_op_e     sp_op;
    cap_sel_e   cap;
    logic       set_done;
    logic       set_err;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                in_valid;
    logic                sp_zero;
    logic                sp_lt2;
    logic                sp_lt3;
    logic                sp_full;
    logic                a_is_str;
    logic                a_is_num;
    logic                pick_bad;
    logic                out_free;
  } dp_status_t;

endpackage

@@ src/tdse_in_if.sv @@
// Input channel of the stack engine: opcode and push operand beats.
interface tdse_in_if;
  logic                            valid;
  logic                            ready;
  logic [tdse_pkg::OPCODE_W-1:0]   opcode;
  logic [tdse_pkg::PORT_VAL_W-1:0] push_value;
  logic [tdse_pkg::TAG_W-1:0]      push_tag;

  modport source (output valid, output opcode, output push_value, output push_tag,
                  input ready);
  modport sink (input valid, input opcode, input push_value, input push_tag,
                output ready);
endinterface

@@ src/tdse_out_if.sv @@
// Output channel of the stack engine: one result beat per operation.
interface tdse_out_if;
  logic                            valid;
  logic                            ready;
  logic                            done_res;
  logic                            error;
  logic [tdse_pkg::PORT_VAL_W-1:0] top_value;
  logic [tdse_pkg::TAG_W-1:0]      top_tag;
  logic [tdse_pkg::DEPTH_W-1:0]    depth;

  modport source (output valid, output done_res, output error, output top_value,
                  output top_tag, output depth, input ready);
  modport sink (input valid, input done_res, input error, input top_value,
                input top_tag, input depth, output ready);
endinterface

@@ src/typed_data_stack_engine.sv @@
// Top level of the typed data stack engine: controller, datapath and checks.
//
// Typed operand stack for a stack-language interpreter. Each input beat
// carries an opcode (push, dup, drop, swap, rot, pick) and, for push, a
// value word and a type tag (long, double, char, string). Every beat yields
// exactly one result beat with done, error, the top element after the
// operation (zero on an empty stack) and the resulting depth. A failing
// operation (underflow, overflow, pick index negative or not below the
// remaining depth) leaves the stack untouched and raises error. Dup of a
// string reports done without copying; a char or string pick index is
// consumed with done and error both low; opcodes 6 and 7 change nothing.
// The stack lives in a single-port-read, single-port-write memory, so operand
// reads, entry writes and the final read of the new top happen one at a time.
// Push, drop, unused opcodes and any operation rejected before its operands are
// read (too few entries or a push on a full stack) go straight to the top read;
// dup reads one entry and writes its copy (not for a string or on a full
// stack); pick reads the index, then, if it is valid, the picked entry and
// writes it over the index; swap reads two entries and writes two; rot reads
// three and writes three. The result sits in an output register, so the next
// beat is taken while an earlier result still waits downstream; the engine
// only holds when a second result is ready before the first was taken.
// Stack contents are not cleared at reset, only the stack pointer.
module typed_data_stack_engine (
  input logic        clk_i,
  input logic        rst_ni,
  tdse_in_if.sink    in_i,
  tdse_out_if.source out_o
);

  tdse_pkg::ctrl_cmd_t  cmd;
  tdse_pkg::dp_status_t status;

  // Sequence the operation steps.
  tdse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Hold the stack, operands and the result beat.
  tdse_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

`ifndef NO_ASSERTIONS
  // A result never claims success and failure at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.done_res && out_o.error))
    else $error("result beat has both done and error set");

  // The stack memory is never written while waiting for a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.in_ready |-> !cmd.wr_en)
    else $error("stack write while idle");

  // One operation at a time: after taking a beat, stop taking beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted again right after a beat");
`endif

endmodule

@@ src/tdse_datapath.sv @@
// Stack memory, stack pointer, operand registers and result register.
module tdse_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tdse_in_if.sink                in_i,
  tdse_out_if.source             out_o,
  input  tdse_pkg::ctrl_cmd_t    cmd_i,
  output tdse_pkg::dp_status_t   status_o
);

  function automatic logic [tdse_pkg::ADDR_W-1:0] sel_addr(
    input tdse_pkg::addr_sel_e           sel,
    input logic [tdse_pkg::SP_W-1:0]     sp,
    input logic [tdse_pkg::ADDR_W-1:0]   pidx
  );
    logic [tdse_pkg::SP_W-1:0]   m1;
    logic [tdse_pkg::SP_W-1:0]   m2;
    logic [tdse_pkg::SP_W-1:0]   m3;
    logic [tdse_pkg::ADDR_W-1:0] res;
    m1 = sp - tdse_pkg::SP_W'(1);
    m2 = sp - tdse_pkg::SP_W'(2);
    m3 = sp - tdse_pkg::SP_W'(3);
    case (sel)
      tdse_pkg::ADDR_SP:    res = sp[tdse_pkg::ADDR_W-1:0];
      tdse_pkg::ADDR_SP_M1: res = m1[tdse_pkg::ADDR_W-1:0];
      tdse_pkg::ADDR_SP_M2: res = m2[tdse_pkg::ADDR_W-1:0];
      tdse_pkg::ADDR_SP_M3: res = m3[tdse_pkg::ADDR_W-1:0];
      tdse_pkg::ADDR_PICK:  res = m2[tdse_pkg::ADDR_W-1:0] - pidx;
      default:              res = m1[tdse_pkg::ADDR_W-1:0];
    endcase
    return res;
  endfunction

  logic                              in_fire;
  logic [tdse_pkg::OPCODE_W-1:0]     op_q;
  logic [tdse_pkg::VALUE_WIDTH-1:0]  in_value_q;
  logic [tdse_pkg::TAG_W-1:0]        in_tag_q;

  logic [tdse_pkg::SP_W-1:0]         sp_q;
  logic [tdse_pkg::SP_W-1:0]         sp_d;
  logic [tdse_pkg::SP_W-1:0]         rest;

  tdse_pkg::entry_t                  stack_mem_q [tdse_pkg::STACK_DEPTH];
  tdse_pkg::entry_t                  rd_q;
  tdse_pkg::entry_t                  a_q;
  tdse_pkg::entry_t                  b_q;
  tdse_pkg::entry_t                  c_q;
  tdse_pkg::entry_t                  wr_data;
  logic [tdse_pkg::ADDR_W-1:0]       rd_addr;
  logic [tdse_pkg::ADDR_W-1:0]       wr_addr;

  logic [tdse_pkg::IDX_W-1:0]        a_ext;
  logic [tdse_pkg::IDX_W-1:0]        pick_idx;
  logic                              pick_neg;

  logic                              done_q;
  logic                              err_q;
  logic                              out_valid_q;
  logic                              out_done_q;
  logic                              out_err_q;
  logic [tdse_pkg::PORT_VAL_W-1:0]   out_value_q;
  logic [tdse_pkg::TAG_W-1:0]        out_tag_q;
  logic [tdse_pkg::DEPTH_W-1:0]      out_depth_q;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid & in_i.ready;

  // Latch the operation beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= in_i.opcode;
      in_value_q <= in_i.push_value[tdse_pkg::VALUE_WIDTH-1:0];
      in_tag_q   <= in_i.push_tag;
    end
  end

  always_comb begin
    case (cmd_i.sp_op)
      tdse_pkg::SP_INC: sp_d = sp_q + tdse_pkg::SP_W'(1);
      tdse_pkg::SP_DEC: sp_d = sp_q - tdse_pkg::SP_W'(1);
      default:          sp_d = sp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (in_fire) begin
      done_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      if (cmd_i.set_done) done_q <= 1'b1;
      if (cmd_i.set_err)  err_q  <= 1'b1;
    end
  end

  // Pick index: long is the whole value, double the low 32 raw bits.
  assign rest  = sp_q - tdse_pkg::SP_W'(1);
  assign a_ext = tdse_pkg::IDX_W'(a_q.value);
  always_comb begin
    if (a_q.tag == tdse_pkg::TAG_LONG) begin
      pick_idx = a_ext;
      pick_neg = a_q.value[tdse_pkg::VALUE_WIDTH-1];
    end else begin
      pick_idx = tdse_pkg::IDX_W'(a_ext[31:0]);
      pick_neg = a_ext[31];
    end
  end

  assign rd_addr = sel_addr(cmd_i.rd_addr, sp_q, pick_idx[tdse_pkg::ADDR_W-1:0]);
  assign wr_addr = sel_addr(cmd_i.wr_addr, sp_q, pick_idx[tdse_pkg::ADDR_W-1:0]);

  always_comb begin
    case (cmd_i.wr_data)
      tdse_pkg::WD_IN: wr_data = '{tag: in_tag_q, value: in_value_q};
      tdse_pkg::WD_A:  wr_data = a_q;
      tdse_pkg::WD_B:  wr_data = b_q;
      tdse_pkg::WD_C:  wr_data = c_q;
      tdse_pkg::WD_RD: wr_data = rd_q;
      default:         wr_data = a_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      stack_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= stack_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      tdse_pkg::CAP_A: a_q <= rd_q;
      tdse_pkg::CAP_B: b_q <= rd_q;
      tdse_pkg::CAP_C: c_q <= rd_q;
      default: ;
    endcase
  end

  // Result register: holds one beat while the next operation runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_done_q  <= done_q;
      out_err_q   <= err_q;
      out_value_q <= (sp_q == '0) ? '0 : tdse_pkg::PORT_VAL_W'(rd_q.value);
      out_tag_q   <= (sp_q == '0) ? '0 : rd_q.tag;
      out_depth_q <= tdse_pkg::DEPTH_W'(sp_q);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.done_res  = out_done_q;
  assign out_o.error     = out_err_q;
  assign out_o.top_value = out_value_q;
  assign out_o.top_tag   = out_tag_q;
  assign out_o.depth     = out_depth_q;

  assign status_o.op       = op_q;
  assign status_o.in_valid = in_i.valid;
  assign status_o.sp_zero  = (sp_q == '0);
  assign status_o.sp_lt2   = (sp_q < tdse_pkg::SP_W'(2));
  assign status_o.sp_lt3   = (sp_q < tdse_pkg::SP_W'(3));
  assign status_o.sp_full  = (sp_q == tdse_pkg::SP_W'(tdse_pkg::STACK_DEPTH));
  assign status_o.a_is_str = (a_q.tag == tdse_pkg::TAG_STR);
  assign status_o.a_is_num = (a_q.tag == tdse_pkg::TAG_LONG) ||
                             (a_q.tag == tdse_pkg::TAG_DOUBLE);
  assign status_o.pick_bad = pick_neg || (pick_idx >= tdse_pkg::IDX_W'(rest));
  assign status_o.out_free = !out_valid_q || out_o.ready;

endmodule

@@ src/tdse_ctrl.sv @@
// Sequencer that steps each stack operation through reads, writes and the top read.
module tdse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdse_pkg::dp_status_t  status_i,
  output tdse_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_DUP,
    ST_PICK,
    ST_PICK_WR,
    ST_WR1,
    ST_WR2,
    ST_WR3,
    ST_TOP,
    ST_TOP_WAIT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_TOP;
        case (status_i.op)
          tdse_pkg::OP_PUSH: begin
            if (status_i.sp_full) begin
              cmd_o.set_err = 1'b1;
            end else begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_addr  = tdse_pkg::ADDR_SP;
              cmd_o.wr_data  = tdse_pkg::WD_IN;
              cmd_o.sp_op    = tdse_pkg::SP_INC;
              cmd_o.set_done = 1'b1;
            end
          end
          tdse_pkg::OP_DROP: begin
            if (status_i.sp_zero) begin
              cmd_o.set_err = 1'b1;
            end else begin
              cmd_o.sp_op    = tdse_pkg::SP_DEC;
              cmd_o.set_done = 1'b1;
            end
          end
          tdse_pkg::OP_DUP, tdse_pkg::OP_PICK: begin
            if (status_i.sp_zero) cmd_o.set_err = 1'b1;
            else                  state_d = ST_RD1;
          end
          tdse_pkg::OP_SWAP: begin
            if (status_i.sp_lt2) cmd_o.set_err = 1'b1;
            else                 state_d = ST_RD1;
          end
          tdse_pkg::OP_ROT: begin
            if (status_i.sp_lt3) cmd_o.set_err = 1'b1;
            else                 state_d = ST_RD1;
          end
          default: ;
        endcase
      end
      ST_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = tdse_pkg::ADDR_SP_M1;
        state_d       = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.cap = tdse_pkg::CAP_A;
        case (status_i.op)
          tdse_pkg::OP_DUP:  state_d = ST_DUP;
          tdse_pkg::OP_PICK: state_d = ST_PICK;
          default: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = tdse_pkg::ADDR_SP_M2;
            state_d       = ST_RD3;
          end
        endcase
      end
      ST_RD3: begin
        cmd_o.cap = tdse_pkg::CAP_B;
        if (status_i.op == tdse_pkg::OP_ROT) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = tdse_pkg::ADDR_SP_M3;
          state_d       = ST_RD4;
        end else begin
          state_d = ST_WR1;
        end
      end
      ST_RD4: begin
        cmd_o.cap = tdse_pkg::CAP_C;
        state_d   = ST_WR1;
      end
      ST_DUP: begin
        state_d = ST_TOP;
        if (status_i.a_is_str) begin
          cmd_o.set_done = 1'b1;
        end else if (status_i.sp_full) begin
          cmd_o.set_err = 1'b1;
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_addr  = tdse_pkg::ADDR_SP;
          cmd_o.wr_data  = tdse_pkg::WD_A;
          cmd_o.sp_op    = tdse_pkg::SP_INC;
          cmd_o.set_done = 1'b1;
        end
      end
      ST_PICK: begin
        state_d = ST_TOP;
        if (!status_i.a_is_num) begin
          cmd_o.sp_op = tdse_pkg::SP_DEC;
        end else if (status_i.pick_bad) begin
          cmd_o.set_err = 1'b1;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = tdse_pkg::ADDR_PICK;
          state_d       = ST_PICK_WR;
        end
      end
      ST_PICK_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_addr  = tdse_pkg::ADDR_SP_M1;
        cmd_o.wr_data  = tdse_pkg::WD_RD;
        cmd_o.set_done = 1'b1;
        state_d        = ST_TOP;
      end
      ST_WR1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = (status_i.op == tdse_pkg::OP_ROT) ? tdse_pkg::ADDR_SP_M3
                                                          : tdse_pkg::ADDR_SP_M1;
        cmd_o.wr_data = tdse_pkg::WD_B;
        state_d       = ST_WR2;
      end
      ST_WR2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = tdse_pkg::ADDR_SP_M2;
        cmd_o.wr_data = tdse_pkg::WD_A;
        if (status_i.op == tdse_pkg::OP_ROT) begin
          state_d = ST_WR3;
        end else begin
          cmd_o.set_done = 1'b1;
          state_d        = ST_TOP;
        end
      end
      ST_WR3: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_addr  = tdse_pkg::ADDR_SP_M1;
        cmd_o.wr_data  = tdse_pkg::WD_C;
        cmd_o.set_done = 1'b1;
        state_d        = ST_TOP;
      end
      ST_TOP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = tdse_pkg::ADDR_SP_M1;
        state_d       = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ verif/typed_data_stack_engine_tb.sv @@
// Testbench for the typed data stack engine: directed and random beats against a shadow stack.
module typed_data_stack_engine_tb;
  import tdse_pkg::*;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned TOTAL_BEATS    = 650;
  localparam int unsigned SQUEEZE_AT     = 250;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT    = 600000;

  // Opcodes outside the defined set; the engine must leave the stack alone.
  localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_CHURN
  } load_phase_e;

  // Shadow of the operand stack: predicts each result beat and checks it.
  class stack_checker;
    typedef struct {
      logic                   done;
      logic                   err;
      logic [PORT_VAL_W-1:0]  top_value;
      logic [TAG_W-1:0]       top_tag;
      logic [DEPTH_W-1:0]     depth;
    } step_status_t;

    logic [VALUE_WIDTH-1:0] slot_value [STACK_DEPTH];
    tag_e                   slot_tag [STACK_DEPTH];
    int unsigned            sp;
    step_status_t           awaited_q [$];
    int unsigned            mismatches;

    function new();
      sp = 0;
      mismatches = 0;
    endfunction

    function step_status_t advance_stack(logic [OPCODE_W-1:0] opc, logic [PORT_VAL_W-1:0] word,
                                         tag_e tag);
      step_status_t           st;
      int unsigned            n;
      int unsigned            rest;
      logic [VALUE_WIDTH-1:0] held_v;
      tag_e                   held_t;
      logic [63:0]            idx;
      logic                   neg;
      n = sp;
      st.done = 1'b0;
      st.err = 1'b0;
      case (opc)
        OP_PUSH: begin
          if (n >= STACK_DEPTH) begin
            st.err = 1'b1;
          end else begin
            slot_value[n] = word[VALUE_WIDTH-1:0];
            slot_tag[n] = tag;
            sp = n + 1;
            st.done = 1'b1;
          end
        end
        OP_DUP: begin
          // A string on top is reported done but never copied.
          if (n == 0) begin
            st.err = 1'b1;
          end else if (slot_tag[n-1] == TAG_STR) begin
            st.done = 1'b1;
          end else if (n >= STACK_DEPTH) begin
            st.err = 1'b1;
          end else begin
            slot_value[n] = slot_value[n-1];
            slot_tag[n] = slot_tag[n-1];
            sp = n + 1;
            st.done = 1'b1;
          end
        end
        OP_DROP: begin
          if (n == 0) begin
            st.err = 1'b1;
          end else begin
            sp = n - 1;
            st.done = 1'b1;
          end
        end
        OP_SWAP: begin
          if (n < 2) begin
            st.err = 1'b1;
          end else begin
            held_v = slot_value[n-1];
            held_t = slot_tag[n-1];
            slot_value[n-1] = slot_value[n-2];
            slot_tag[n-1] = slot_tag[n-2];
            slot_value[n-2] = held_v;
            slot_tag[n-2] = held_t;
            st.done = 1'b1;
          end
        end
        OP_ROT: begin
          if (n < 3) begin
            st.err = 1'b1;
          end else begin
            held_v = slot_value[n-3];
            held_t = slot_tag[n-3];
            slot_value[n-3] = slot_value[n-2];
            slot_tag[n-3] = slot_tag[n-2];
            slot_value[n-2] = slot_value[n-1];
            slot_tag[n-2] = slot_tag[n-1];
            slot_value[n-1] = held_v;
            slot_tag[n-1] = held_t;
            st.done = 1'b1;
          end
        end
        OP_PICK: begin
          if (n == 0) begin
            st.err = 1'b1;
          end else begin
            held_v = slot_value[n-1];
            held_t = slot_tag[n-1];
            rest = n - 1;
            if (held_t == TAG_LONG || held_t == TAG_DOUBLE) begin
              // Long: full word, signed. Double: low 32 raw bits, signed.
              if (held_t == TAG_LONG) begin
                idx = 64'(held_v);
                neg = held_v[VALUE_WIDTH-1];
              end else begin
                idx = {32'b0, held_v[31:0]};
                neg = held_v[31];
              end
              if (neg || idx >= 64'(rest)) begin
                st.err = 1'b1;
              end else begin
                slot_value[n-1] = slot_value[rest - 1 - idx[31:0]];
                slot_tag[n-1] = slot_tag[rest - 1 - idx[31:0]];
                st.done = 1'b1;
              end
            end else begin
              // Char or string index: consume it, push nothing.
              sp = rest;
            end
          end
        end
        default: begin
        end
      endcase
      if (sp > 0) begin
        st.top_value = PORT_VAL_W'(slot_value[sp-1]);
        st.top_tag = slot_tag[sp-1];
      end else begin
        st.top_value = '0;
        st.top_tag = '0;
      end
      st.depth = DEPTH_W'(sp);
      return st;
    endfunction

    function void note_beat(logic [OPCODE_W-1:0] opc, logic [PORT_VAL_W-1:0] word, tag_e tag);
      awaited_q.push_back(advance_stack(opc, word, tag));
    endfunction

    task report(string msg);
      mismatches++;
      $display("tb: mismatch: %s", msg);
    endtask

    task check_result(logic done, logic err, logic [PORT_VAL_W-1:0] top_value,
                      logic [TAG_W-1:0] top_tag, logic [DEPTH_W-1:0] depth);
      step_status_t exp_st;
      if (awaited_q.size() == 0) begin
        report("result beat with no operation outstanding");
      end else begin
        exp_st = awaited_q.pop_front();
        if (done !== exp_st.done)
          report($sformatf("done_res %b, expected %b", done, exp_st.done));
        if (err !== exp_st.err)
          report($sformatf("error %b, expected %b", err, exp_st.err));
        if (top_value !== exp_st.top_value)
          report($sformatf("top_value %h, expected %h", top_value, exp_st.top_value));
        if (top_tag !== exp_st.top_tag)
          report($sformatf("top_tag %0d, expected %0d", top_tag, exp_st.top_tag));
        if (depth !== exp_st.depth)
          report($sformatf("depth %0d, expected %0d", depth, exp_st.depth));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          steady = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  stack_checker sb = new();

  tdse_in_if  in_bus ();
  tdse_out_if out_bus ();

  typed_data_stack_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic logic [PORT_VAL_W-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return PORT_VAL_W'(1) << $urandom_range(0, PORT_VAL_W - 1);
    return {$urandom, $urandom};
  endfunction

  function automatic tag_e rand_tag();
    return tag_e'($urandom_range(0, 3));
  endfunction

  // Weighted opcode draw; the weights shift the stack toward full, empty or neither.
  function automatic logic [OPCODE_W-1:0] draw_op(load_phase_e ph);
    // push, dup, drop, swap, rot, pick, unused 6, unused 7
    int w [8];
    int total;
    int r;
    int k;
    case (ph)
      PHASE_FILL:  w = '{60, 10, 6, 6, 6, 10, 1, 1};
      PHASE_DRAIN: w = '{12, 6, 50, 8, 8, 14, 1, 1};
      default:     w = '{30, 12, 22, 12, 12, 10, 1, 1};
    endcase
    total = 0;
    foreach (w[i]) total += w[i];
    r = $urandom_range(0, total - 1);
    for (k = 0; k < 8; k++) begin
      if (r < w[k]) return OPCODE_W'(k);
      r -= w[k];
    end
    return OP_PUSH;
  endfunction

  // Offer one beat, hold it until accepted, then record it and maybe idle.
  task automatic send_beat(logic [OPCODE_W-1:0] opc, logic [PORT_VAL_W-1:0] word, tag_e tag);
    int unsigned gap;
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= opc;
    in_bus.push_value <= word;
    in_bus.push_tag   <= tag;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_beat(opc, word, tag);
    beats_sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Push an index of some flavor, then pick with it. Most indexes are in range.
  task automatic send_pick_probe();
    int unsigned            below;
    int unsigned            r;
    logic [PORT_VAL_W-1:0] word;
    tag_e                   tag;
    below = sb.sp;
    if (below >= STACK_DEPTH) begin
      send_beat(OP_PICK, rand_word(), rand_tag());
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      tag = TAG_LONG;
      word = PORT_VAL_W'($urandom_range(0, below));
    end else if (r < 80) begin
      tag = TAG_DOUBLE;
      word = {$urandom, 1'b0, 31'($urandom_range(0, below))};
    end else if (r < 88) begin
      tag = TAG_LONG;
      word = {1'b1, 31'($urandom), $urandom};
    end else if (r < 92) begin
      tag = TAG_DOUBLE;
      word = {$urandom, 1'b1, 31'($urandom)};
    end else begin
      tag = ($urandom_range(0, 1) == 0) ? TAG_CHAR : TAG_STR;
      word = rand_word();
    end
    send_beat(OP_PUSH, word, tag);
    send_beat(OP_PICK, rand_word(), rand_tag());
  endtask

  // Underflow on every opcode that can underflow, the string dup, then each pick flavor.
  task automatic run_directed();
    send_beat(OP_DROP, '0, TAG_LONG);
    send_beat(OP_DUP, '1, TAG_STR);
    send_beat(OP_SWAP, '0, TAG_LONG);
    send_beat(OP_ROT, '0, TAG_LONG);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_UNUSED_6, '1, TAG_STR);
    send_beat(OP_PUSH, '0, TAG_LONG);
    send_beat(OP_SWAP, '0, TAG_LONG);
    send_beat(OP_PUSH, '1, TAG_STR);
    send_beat(OP_DUP, '0, TAG_LONG);
    send_beat(OP_ROT, '0, TAG_LONG);
    // Double index: upper half is noise, low half selects entry one below.
    send_beat(OP_PUSH, 64'hFFFF_FFFF_0000_0001, TAG_DOUBLE);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'h8000_0000_0000_0000, TAG_LONG);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'h0000_0000_8000_0000, TAG_DOUBLE);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'h41, TAG_CHAR);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'h24, TAG_STR);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'd9, TAG_LONG);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_PUSH, 64'd0, TAG_LONG);
    send_beat(OP_PICK, '0, TAG_LONG);
    send_beat(OP_DUP, '0, TAG_LONG);
    send_beat(OP_SWAP, '0, TAG_LONG);
    send_beat(OP_ROT, '0, TAG_LONG);
    send_beat(OP_UNUSED_7, '0, TAG_LONG);
  endtask

  // Segments of fill, drain and churn; the first one fills to overflow.
  task automatic run_random();
    load_phase_e           ph;
    int unsigned           seg_len;
    int unsigned           seg_idx;
    logic [OPCODE_W-1:0]   opc;
    seg_idx = 0;
    while (beats_sent < TOTAL_BEATS) begin
      if (seg_idx == 0) begin
        ph = PHASE_FILL;
        seg_len = 110;
      end else begin
        ph = load_phase_e'($urandom_range(0, 2));
        seg_len = $urandom_range(30, 120);
      end
      seg_idx++;
      steady = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        if (beats_sent >= TOTAL_BEATS) break;
        if (!squeeze_done && beats_sent >= SQUEEZE_AT) begin
          squeeze_req = 1'b1;
          squeeze_done = 1'b1;
        end
        opc = draw_op(ph);
        if (opc == OP_PICK && $urandom_range(0, 99) < 70) begin
          send_pick_probe();
        end else begin
          send_beat(opc, rand_word(), rand_tag());
        end
      end
    end
    steady = 1'b0;
  endtask

  // Stimulus: reset once, directed beats, random beats, then drain.
  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= '0;
    in_bus.push_value <= '0;
    in_bus.push_tag   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_bus.valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: bursts of ready, random stalls, and one long hold-off so the
  // output register fills and the engine must stall its input.
  initial begin
    int unsigned run;
    int unsigned stall;
    int unsigned held;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      repeat (run) begin
        @(posedge clk_i);
        out_bus.ready <= 1'b1;
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        held = 0;
        while (held < SQUEEZE_CYCLES) begin
          @(posedge clk_i);
          out_bus.ready <= 1'b0;
          held++;
        end
      end else begin
        stall = idle_len();
        repeat (stall) begin
          @(posedge clk_i);
          out_bus.ready <= 1'b0;
        end
      end
    end
  end

  // Check every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_result(out_bus.done_res, out_bus.error, out_bus.top_value, out_bus.top_tag,
                      out_bus.depth);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
src/tdse_pkg.sv
src/tdse_in_if.sv
src/tdse_out_if.sv
src/tdse_datapath.sv
src/tdse_ctrl.sv
src/typed_data_stack_engine.sv
verif/typed_data_stack_engine_tb.sv
